// ----- rtl/core/dmwbc_pkg.sv -----
//------------------------------------------------------------------------------
// dmwbc_pkg
// shared types and constants for the direct-mapped write-back cache model
//------------------------------------------------------------------------------
package dmwbc_pkg;

    // cache geometry
    localparam int CACHE_BYTES = 8192;
    localparam int LINE_BYTES  = 64;
    localparam int NUM_LINES   = CACHE_BYTES / LINE_BYTES;
    localparam int ADDR_W      = 64;
    localparam int OFF_BITS    = $clog2(LINE_BYTES);
    localparam int IDX_BITS    = $clog2(NUM_LINES);
    localparam int TAG_SHIFT   = OFF_BITS + IDX_BITS;
    localparam int TAG_BITS    = ADDR_W - TAG_SHIFT;
    localparam int BYTES_W     = 7;
    localparam int SPAN_W      = ((OFF_BITS > BYTES_W) ? OFF_BITS : BYTES_W) + 1;

    // cost and totals
    localparam int HIT_CYC_W  = 8;
    localparam int MISS_CYC_W = 16;
    localparam int WB_CYC_W   = 16;
    localparam int COST_W     = 17;
    localparam int TOTAL_W    = 64;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_CYCLES       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_CYCLES      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITEBACK_CYCLES = 2'd2;

    localparam logic [HIT_CYC_W-1:0]  HIT_CYCLES_RST       = 8'd1;
    localparam logic [MISS_CYC_W-1:0] MISS_CYCLES_RST      = 16'd200;
    localparam logic [WB_CYC_W-1:0]   WRITEBACK_CYCLES_RST = 16'd50;

    // queue between front and back
    localparam int QPTR_W      = 1;
    localparam int QUEUE_DEPTH = 2 ** QPTR_W;
    localparam int QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic [HIT_CYC_W-1:0]  hit_cycles;
        logic [MISS_CYC_W-1:0] miss_cycles;
        logic [WB_CYC_W-1:0]   writeback_cycles;
    } cfg_t;

    // classified access as it sits in the queue
    typedef struct packed {
        logic                split;
        logic                is_write;
        logic [IDX_BITS-1:0] idx;
        logic [TAG_BITS-1:0] tag;
    } item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC
    } back_state_t;

endpackage

// ----- rtl/core/dmwbc_ram.sv -----
//------------------------------------------------------------------------------
// dmwbc_ram
// generic single-write, single-read ram with registered read data
//------------------------------------------------------------------------------
module dmwbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/dmwbc_front.sv -----
//------------------------------------------------------------------------------
// dmwbc_front
// accepts accesses, splits address into index and tag, flags line splits,
// and holds them in a short queue for the back end
//------------------------------------------------------------------------------
module dmwbc_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dmwbc_pkg::ADDR_W-1:0]    address,
    input  logic                            is_write,
    input  logic [dmwbc_pkg::BYTES_W-1:0]   access_bytes,
    output logic                            q_valid,
    output dmwbc_pkg::item_t                q_item,
    input  logic                            q_pop
);
    import dmwbc_pkg::*;

    item_t             q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [SPAN_W-1:0] span;
    item_t             cls;
    logic              push;
    logic              pop;

    // classification
    always_comb
    begin
        span         = SPAN_W'(address[OFF_BITS-1:0]) + SPAN_W'(access_bytes);
        cls.split    = (span > SPAN_W'(LINE_BYTES));
        cls.is_write = is_write;
        cls.idx      = address[OFF_BITS +: IDX_BITS];
        cls.tag      = address[ADDR_W-1:TAG_SHIFT];
    end

    assign in_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ----- rtl/core/dmwbc_back.sv -----
//------------------------------------------------------------------------------
// dmwbc_back
// looks up the tag store, updates line state and running totals,
// and holds the result in the output register
//------------------------------------------------------------------------------
module dmwbc_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dmwbc_pkg::cfg_t                  cfg,
    input  logic                             q_valid,
    input  dmwbc_pkg::item_t                 q_item,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             hit,
    output logic                             split_error,
    output logic                             wrote_back,
    output logic [dmwbc_pkg::COST_W-1:0]     access_cost,
    output logic [dmwbc_pkg::TOTAL_W-1:0]    hit_total,
    output logic [dmwbc_pkg::TOTAL_W-1:0]    miss_total,
    output logic [dmwbc_pkg::TOTAL_W-1:0]    access_total,
    output logic [dmwbc_pkg::TOTAL_W-1:0]    hit_cycle_total,
    output logic [dmwbc_pkg::TOTAL_W-1:0]    miss_cycle_total,
    output logic [dmwbc_pkg::TOTAL_W-1:0]    time_total
);
    import dmwbc_pkg::*;

    back_state_t          state_reg, state_next;
    item_t                cur_reg;
    logic [NUM_LINES-1:0] line_valid_reg, line_dirty_reg;
    logic [TAG_BITS-1:0]  tag_rd;
    logic                 rd_en, fire, tag_wr;
    logic                 lk_valid, lk_dirty, lk_hit, lk_wb;
    logic [COST_W-1:0]    cost;
    logic                 out_valid_reg, out_valid_next;

    logic [TOTAL_W-1:0] hits_reg, hits_next;
    logic [TOTAL_W-1:0] misses_reg, misses_next;
    logic [TOTAL_W-1:0] accesses_reg, accesses_next;
    logic [TOTAL_W-1:0] hit_sum_reg, hit_sum_next;
    logic [TOTAL_W-1:0] miss_sum_reg, miss_sum_next;
    logic [TOTAL_W-1:0] elapsed_reg, elapsed_next;

    dmwbc_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (NUM_LINES)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_wr),
        .wr_addr (cur_reg.idx),
        .wr_data (cur_reg.tag),
        .rd_en   (rd_en),
        .rd_addr (q_item.idx),
        .rd_data (tag_rd)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (q_valid) state_next = BK_EXEC;
            BK_EXEC: if (fire)    state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop = 1'b0;
        rd_en = 1'b0;
        fire  = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                q_pop = q_valid;
                rd_en = q_valid;
            end
            BK_EXEC:
            begin
                fire = !out_valid_reg || !out_stall;
            end
            default: ;
        endcase
    end

    // lookup
    always_comb
    begin
        lk_valid = line_valid_reg[cur_reg.idx];
        lk_dirty = line_dirty_reg[cur_reg.idx];
        lk_hit   = lk_valid && (tag_rd == cur_reg.tag);
        lk_wb    = !lk_hit && lk_valid && lk_dirty;
        if (lk_hit)
        begin
            cost = COST_W'(cfg.hit_cycles);
        end
        else
        begin
            cost = COST_W'(cfg.miss_cycles)
                 + (lk_wb ? COST_W'(cfg.writeback_cycles) : '0);
        end
        tag_wr = fire && !cur_reg.split && !lk_hit;
    end

    // running totals
    always_comb
    begin
        hits_next     = hits_reg;
        misses_next   = misses_reg;
        accesses_next = accesses_reg;
        hit_sum_next  = hit_sum_reg;
        miss_sum_next = miss_sum_reg;
        elapsed_next  = elapsed_reg;
        if (fire && !cur_reg.split)
        begin
            accesses_next = accesses_reg + 1'b1;
            elapsed_next  = elapsed_reg + TOTAL_W'(cost);
            if (lk_hit)
            begin
                hits_next    = hits_reg + 1'b1;
                hit_sum_next = hit_sum_reg + TOTAL_W'(cfg.hit_cycles);
            end
            else
            begin
                misses_next   = misses_reg + 1'b1;
                miss_sum_next = miss_sum_reg + TOTAL_W'(cfg.miss_cycles);
            end
        end
    end

    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            out_valid_reg  <= 1'b0;
            line_valid_reg <= '0;
            line_dirty_reg <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            accesses_reg   <= '0;
            hit_sum_reg    <= '0;
            miss_sum_reg   <= '0;
            elapsed_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            accesses_reg  <= accesses_next;
            hit_sum_reg   <= hit_sum_next;
            miss_sum_reg  <= miss_sum_next;
            elapsed_reg   <= elapsed_next;
            if (fire && !cur_reg.split)
            begin
                line_valid_reg[cur_reg.idx] <= 1'b1;
                line_dirty_reg[cur_reg.idx] <= lk_hit ? (lk_dirty || cur_reg.is_write)
                                                      : cur_reg.is_write;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
        if (fire)
        begin
            hit              <= !cur_reg.split && lk_hit;
            split_error      <= cur_reg.split;
            wrote_back       <= !cur_reg.split && lk_wb;
            access_cost      <= cur_reg.split ? '0 : cost;
            hit_total        <= hits_next;
            miss_total       <= misses_next;
            access_total     <= accesses_next;
            hit_cycle_total  <= hit_sum_next;
            miss_cycle_total <= miss_sum_next;
            time_total       <= elapsed_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/direct_mapped_writeback_cache_model_top.sv -----
//------------------------------------------------------------------------------
// direct_mapped_writeback_cache_model_top
// direct-mapped, write-allocate, write-back cache model with cost accounting
//------------------------------------------------------------------------------
// usage
//   input channel: address, is_write, access_bytes under in_valid / in_stall;
//   a transaction is taken when in_valid is high and in_stall is low
//   output channel: one result per input transaction under out_valid /
//   out_stall, in input order, with hit / miss, split flag, writeback flag,
//   cost of the access and the six running totals after it
//   config: cfg_write with cfg_index (0 hit, 1 miss, 2 writeback cycles)
//   and cfg_data; only while the block is idle, other indexes are ignored
//   an access is written into the queue, then popped with the tag ram read
//   in the idle state, then compared and its line updated in the exec state,
//   which registers the result; the back end takes one access at a time
//   a 2-entry queue sits between classification and lookup, so input keeps
//   flowing while the back end waits on a stalled output
//   out_stall holds the result register and, once the queue fills, in_stall
//   reset: line valid and dirty bits, totals and queue are cleared at once,
//   cycle costs return to 1 / 200 / 50; no clearing pass is needed
//------------------------------------------------------------------------------
module direct_mapped_writeback_cache_model_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_write,
    input  logic [dmwbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmwbc_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [dmwbc_pkg::ADDR_W-1:0]     address,
    input  logic                             is_write,
    input  logic [dmwbc_pkg::BYTES_W-1:0]    access_bytes,
    // output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             hit,
    output logic                             split_error,
    output logic                             wrote_back,
    output logic [dmwbc_pkg::COST_W-1:0]     access_cost,
    output logic [dmwbc_pkg::TOTAL_W-1:0]    hit_total,
    output logic [dmwbc_pkg::TOTAL_W-1:0]    miss_total,
    output logic [dmwbc_pkg::TOTAL_W-1:0]    access_total,
    output logic [dmwbc_pkg::TOTAL_W-1:0]    hit_cycle_total,
    output logic [dmwbc_pkg::TOTAL_W-1:0]    miss_cycle_total,
    output logic [dmwbc_pkg::TOTAL_W-1:0]    time_total
);
    import dmwbc_pkg::*;

    cfg_t  cfg_reg;
    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    // cycle cost registers; write only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hit_cycles       <= HIT_CYCLES_RST;
            cfg_reg.miss_cycles      <= MISS_CYCLES_RST;
            cfg_reg.writeback_cycles <= WRITEBACK_CYCLES_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HIT_CYCLES:       cfg_reg.hit_cycles       <= cfg_data[HIT_CYC_W-1:0];
                CFG_MISS_CYCLES:      cfg_reg.miss_cycles      <= cfg_data[MISS_CYC_W-1:0];
                CFG_WRITEBACK_CYCLES: cfg_reg.writeback_cycles <= cfg_data[WB_CYC_W-1:0];
                default: ;
            endcase
        end
    end

    // front end: classify and queue
    dmwbc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .address      (address),
        .is_write     (is_write),
        .access_bytes (access_bytes),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    // back end: lookup, line update, totals, result register
    dmwbc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .hit              (hit),
        .split_error      (split_error),
        .wrote_back       (wrote_back),
        .access_cost      (access_cost),
        .hit_total        (hit_total),
        .miss_total       (miss_total),
        .access_total     (access_total),
        .hit_cycle_total  (hit_cycle_total),
        .miss_cycle_total (miss_cycle_total),
        .time_total       (time_total)
    );

endmodule

// ----- rtl/core/dmwbc_checker.sv -----
//------------------------------------------------------------------------------
// dmwbc_checker
// port-level checks on the cache model results
//------------------------------------------------------------------------------
module dmwbc_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             hit,
    input  logic                             split_error,
    input  logic                             wrote_back,
    input  logic [dmwbc_pkg::COST_W-1:0]     access_cost,
    input  logic [dmwbc_pkg::TOTAL_W-1:0]    hit_total,
    input  logic [dmwbc_pkg::TOTAL_W-1:0]    miss_total,
    input  logic [dmwbc_pkg::TOTAL_W-1:0]    access_total
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a split transaction reports no hit, no writeback and no cost
    a_split_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && split_error |-> !hit && !wrote_back && access_cost == '0)
        else $error("split transaction carries lookup results");

    // a writeback only happens on a miss
    a_wb_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wrote_back |-> !hit)
        else $error("writeback reported on a hit");

    // every counted access is either a hit or a miss
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hit_total + miss_total == access_total)
        else $error("hit and miss totals disagree with access total");

endmodule

bind direct_mapped_writeback_cache_model_top dmwbc_checker u_checker (.*);

// ----- test/cache_access_checker.sv -----
//------------------------------------------------------------------------------
// cache_access_checker
// watches both channels and the config port of the cache model, keeps its own
// copy of the line tags, valid / dirty bits, cycle costs and running totals,
// and compares every result transaction against the oldest predicted outcome
//------------------------------------------------------------------------------
module cache_access_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [dmwbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmwbc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [dmwbc_pkg::ADDR_W-1:0]     address,
    input  logic                             is_write,
    input  logic [dmwbc_pkg::BYTES_W-1:0]    access_bytes,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             hit,
    input  logic                             split_error,
    input  logic                             wrote_back,
    input  logic [dmwbc_pkg::COST_W-1:0]     access_cost,
    input  logic [dmwbc_pkg::TOTAL_W-1:0]    hit_total,
    input  logic [dmwbc_pkg::TOTAL_W-1:0]    miss_total,
    input  logic [dmwbc_pkg::TOTAL_W-1:0]    access_total,
    input  logic [dmwbc_pkg::TOTAL_W-1:0]    hit_cycle_total,
    input  logic [dmwbc_pkg::TOTAL_W-1:0]    miss_cycle_total,
    input  logic [dmwbc_pkg::TOTAL_W-1:0]    time_total,
    output int                               mismatches,
    output int                               pending
);

    import dmwbc_pkg::*;

    typedef struct packed {
        logic               hit;
        logic               split_error;
        logic               wrote_back;
        logic [COST_W-1:0]  access_cost;
        logic [TOTAL_W-1:0] hit_total;
        logic [TOTAL_W-1:0] miss_total;
        logic [TOTAL_W-1:0] access_total;
        logic [TOTAL_W-1:0] hit_cycle_total;
        logic [TOTAL_W-1:0] miss_cycle_total;
        logic [TOTAL_W-1:0] time_total;
    } lookup_outcome_t;

    lookup_outcome_t outcome_q[$];

    // cycle costs as last written
    logic [HIT_CYC_W-1:0]  hit_cost;
    logic [MISS_CYC_W-1:0] miss_cost;
    logic [WB_CYC_W-1:0]   evict_cost;

    // line state
    logic [TAG_BITS-1:0] tag_store [NUM_LINES];
    bit                  valid_bits[NUM_LINES];
    bit                  dirty_bits[NUM_LINES];

    // running totals
    logic [TOTAL_W-1:0] hit_count;
    logic [TOTAL_W-1:0] miss_count;
    logic [TOTAL_W-1:0] access_count;
    logic [TOTAL_W-1:0] hit_cycle_sum;
    logic [TOTAL_W-1:0] miss_cycle_sum;
    logic [TOTAL_W-1:0] cycle_count;

    int results_seen;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        // keep the log short when everything goes wrong
        if (mismatches < 200)
            $display("mismatch at result %0d: %s got 0x%0h, want 0x%0h",
                     results_seen, what, got, want);
        mismatches = mismatches + 1;
    endtask

    task automatic lookup_and_account(input logic [ADDR_W-1:0] addr, input logic store,
                                      input logic [BYTES_W-1:0] nbytes);
        lookup_outcome_t     o;
        logic [IDX_BITS-1:0] idx;
        logic [TAG_BITS-1:0] tag;
        o   = '0;
        idx = addr[TAG_SHIFT-1:OFF_BITS];
        tag = addr[ADDR_W-1:TAG_SHIFT];
        if (int'(addr[OFF_BITS-1:0]) + int'(nbytes) > LINE_BYTES)
        begin
            // crosses into the next line: nothing changes
            o.split_error = 1'b1;
        end
        else
        begin
            access_count = access_count + 1;
            if (valid_bits[idx] && tag_store[idx] == tag)
            begin
                o.hit         = 1'b1;
                o.access_cost = hit_cost;
                hit_count     = hit_count + 1;
                hit_cycle_sum = hit_cycle_sum + hit_cost;
                if (store)
                    dirty_bits[idx] = 1'b1;
            end
            else
            begin
                o.access_cost  = miss_cost;
                miss_count     = miss_count + 1;
                miss_cycle_sum = miss_cycle_sum + miss_cost;
                if (valid_bits[idx] && dirty_bits[idx])
                begin
                    o.wrote_back  = 1'b1;
                    o.access_cost = o.access_cost + evict_cost;
                end
                // allocate; a load fill is clean
                valid_bits[idx] = 1'b1;
                tag_store[idx]  = tag;
                dirty_bits[idx] = store;
            end
            cycle_count = cycle_count + o.access_cost;
        end
        o.hit_total        = hit_count;
        o.miss_total       = miss_count;
        o.access_total     = access_count;
        o.hit_cycle_total  = hit_cycle_sum;
        o.miss_cycle_total = miss_cycle_sum;
        o.time_total       = cycle_count;
        outcome_q.push_back(o);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lookup_outcome_t want;
        if (!rst_n)
        begin
            hit_cost   = HIT_CYCLES_RST;
            miss_cost  = MISS_CYCLES_RST;
            evict_cost = WRITEBACK_CYCLES_RST;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                valid_bits[i] = 1'b0;
                dirty_bits[i] = 1'b0;
            end
            hit_count      = '0;
            miss_count     = '0;
            access_count   = '0;
            hit_cycle_sum  = '0;
            miss_cycle_sum = '0;
            cycle_count    = '0;
            outcome_q.delete();
            results_seen = 0;
            mismatches   = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_HIT_CYCLES:       hit_cost   = cfg_data[HIT_CYC_W-1:0];
                    CFG_MISS_CYCLES:      miss_cost  = cfg_data[MISS_CYC_W-1:0];
                    CFG_WRITEBACK_CYCLES: evict_cost = cfg_data[WB_CYC_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                lookup_and_account(address, is_write, access_bytes);
            if (out_valid && !out_stall)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch("result with nothing expected, access_total",
                                    access_total, 64'd0);
                else
                begin
                    want = outcome_q.pop_front();
                    if (hit !== want.hit)
                        report_mismatch("hit", hit, want.hit);
                    if (split_error !== want.split_error)
                        report_mismatch("split_error", split_error, want.split_error);
                    if (wrote_back !== want.wrote_back)
                        report_mismatch("wrote_back", wrote_back, want.wrote_back);
                    if (access_cost !== want.access_cost)
                        report_mismatch("access_cost", access_cost, want.access_cost);
                    if (hit_total !== want.hit_total)
                        report_mismatch("hit_total", hit_total, want.hit_total);
                    if (miss_total !== want.miss_total)
                        report_mismatch("miss_total", miss_total, want.miss_total);
                    if (access_total !== want.access_total)
                        report_mismatch("access_total", access_total, want.access_total);
                    if (hit_cycle_total !== want.hit_cycle_total)
                        report_mismatch("hit_cycle_total", hit_cycle_total,
                                        want.hit_cycle_total);
                    if (miss_cycle_total !== want.miss_cycle_total)
                        report_mismatch("miss_cycle_total", miss_cycle_total,
                                        want.miss_cycle_total);
                    if (time_total !== want.time_total)
                        report_mismatch("time_total", time_total, want.time_total);
                end
                results_seen = results_seen + 1;
            end
        end
        pending = outcome_q.size();
    end

endmodule

// ----- test/tb.sv -----
//------------------------------------------------------------------------------
// tb
// drives memory accesses and cost register writes into the cache model, with
// random gaps on the input side and random stalls on the result side; a
// checker beside the block predicts every result and counts mismatches
//------------------------------------------------------------------------------
module tb;

    import dmwbc_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_ITEMS   = 150;
    localparam int PHASES        = 5;
    localparam int LIMIT_CYCLES  = 300000;
    localparam int MAX_GAP       = 16;

    // index that maps to no register, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // every input known from time zero
    logic                  cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic [ADDR_W-1:0]     address      = '0;
    logic                  is_write     = 1'b0;
    logic [BYTES_W-1:0]    access_bytes = '0;
    logic                  out_stall    = 1'b0;

    logic               in_stall;
    logic               out_valid;
    logic               hit;
    logic               split_error;
    logic               wrote_back;
    logic [COST_W-1:0]  access_cost;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
    logic [TOTAL_W-1:0] access_total;
    logic [TOTAL_W-1:0] hit_cycle_total;
    logic [TOTAL_W-1:0] miss_cycle_total;
    logic [TOTAL_W-1:0] time_total;

    int mismatches;
    int pending;

    // burst modes: while set, that side never idles
    bit feed_quiet  = 1'b0;
    bit drain_quiet = 1'b0;

    // small pool of tags so that random accesses keep hitting and evicting
    logic [TAG_BITS-1:0] tag_pool[4];

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    direct_mapped_writeback_cache_model_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .address          (address),
        .is_write         (is_write),
        .access_bytes     (access_bytes),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .hit              (hit),
        .split_error      (split_error),
        .wrote_back       (wrote_back),
        .access_cost      (access_cost),
        .hit_total        (hit_total),
        .miss_total       (miss_total),
        .access_total     (access_total),
        .hit_cycle_total  (hit_cycle_total),
        .miss_cycle_total (miss_cycle_total),
        .time_total       (time_total)
    );

    cache_access_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .address          (address),
        .is_write         (is_write),
        .access_bytes     (access_bytes),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .hit              (hit),
        .split_error      (split_error),
        .wrote_back       (wrote_back),
        .access_cost      (access_cost),
        .hit_total        (hit_total),
        .miss_total       (miss_total),
        .access_total     (access_total),
        .hit_cycle_total  (hit_cycle_total),
        .miss_cycle_total (miss_cycle_total),
        .time_total       (time_total),
        .mismatches       (mismatches),
        .pending          (pending)
    );

    // address from tag, line index and byte offset
    function automatic logic [ADDR_W-1:0] line_addr(input logic [TAG_BITS-1:0] tag,
                                                    input int idx, input int off);
        return {tag, IDX_BITS'(idx), OFF_BITS'(off)};
    endfunction

    // one input transaction: optional gap, then hold until taken
    task automatic send_access(input logic [ADDR_W-1:0] a, input logic w,
                               input logic [BYTES_W-1:0] n);
        int gap;
        gap = feed_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 15) == 0)
            feed_quiet = !feed_quiet;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        address      <= a;
        is_write     <= w;
        access_bytes <= n;
        do @(posedge clk); while (in_stall);
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // stop feeding, wait for every predicted result, then let the pipe drain
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // random access: mostly well-formed hits and conflicts on a few hot lines,
    // some fully random addresses and some line-crossing byte counts
    task automatic draw_access(output logic [ADDR_W-1:0] a, output logic w,
                               output logic [BYTES_W-1:0] n);
        int off;
        int idx;
        if ($urandom_range(0, 99) < 8)
            a = {$urandom, $urandom};
        else
        begin
            idx = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 7)
                                              : $urandom_range(0, NUM_LINES - 1);
            a = line_addr(tag_pool[$urandom_range(0, 3)], idx,
                          $urandom_range(0, LINE_BYTES - 1));
        end
        off = int'(a[OFF_BITS-1:0]);
        w   = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 12)
            n = BYTES_W'($urandom_range(0, (1 << BYTES_W) - 1));
        else
            n = BYTES_W'($urandom_range(0, LINE_BYTES - off));
    endtask

    // result side: per transaction a random stall, sometimes none for a while
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = drain_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 15) == 0)
                drain_quiet = !drain_quiet;
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // main sequence
    initial
    begin
        logic [ADDR_W-1:0]  a;
        logic               w;
        logic [BYTES_W-1:0] n;

        tag_pool[0] = '0;
        tag_pool[1] = '1;
        tag_pool[2] = TAG_BITS'({$urandom, $urandom});
        tag_pool[3] = TAG_BITS'({$urandom, $urandom});

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, reset cycle costs
        send_access(line_addr('0, 0, 0), 1'b0, 7'd1);            // cold read miss
        send_access(line_addr('0, 0, 0), 1'b0, 7'd64);           // whole line hit
        send_access(line_addr('0, 0, 63), 1'b1, 7'd1);           // store hit, line dirty
        send_access(line_addr(TAG_BITS'(1), 0, 0), 1'b0, 7'd0);  // zero bytes, dirty victim
        send_access(line_addr('0, 0, 0), 1'b0, 7'd8);            // read fill left it clean
        send_access(line_addr('0, 0, 63), 1'b0, 7'd2);           // crosses the line
        send_access(line_addr('0, 0, 1), 1'b1, 7'd64);           // crosses by one byte
        send_access(line_addr('0, 0, 0), 1'b1, 7'd127);          // largest byte count
        send_access(line_addr('0, 0, 0), 1'b0, 7'd65);           // more than a line
        send_access(line_addr(TAG_BITS'(2), 5, 0), 1'b1, 7'd4);  // store miss, invalid line
        send_access(line_addr(TAG_BITS'(3), 5, 8), 1'b0, 7'd4);  // load evicts dirty line
        send_access(line_addr(TAG_BITS'(2), 5, 0), 1'b0, 7'd4);  // clean victim, no evict
        send_access('1, 1'b1, 7'd1);                             // top address, last byte
        send_access(line_addr('1, NUM_LINES - 1, 0), 1'b0, 7'd64);
        send_access(line_addr('0, NUM_LINES - 1, 0), 1'b1, 7'd32);
        send_access(line_addr('0, NUM_LINES - 1, 32), 1'b1, 7'd32);
        send_access(64'h8000_0000_0000_0000, 1'b0, 7'd16);
        send_access(64'h5555_5555_5555_5555, 1'b1, 7'd7);
        send_access(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 7'd22);
        send_access(line_addr('0, 0, 0), 1'b1, 7'd0);            // zero-byte store

        // random part, one cost setting per phase
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    write_reg(CFG_HIT_CYCLES, '0);
                    write_reg(CFG_MISS_CYCLES, '0);
                    write_reg(CFG_WRITEBACK_CYCLES, '0);
                end
                1:
                begin
                    write_reg(CFG_HIT_CYCLES, CFG_DATA_W'(8'hFF));
                    write_reg(CFG_MISS_CYCLES, '1);
                    write_reg(CFG_WRITEBACK_CYCLES, '1);
                end
                2:
                begin
                    // upper data bits set on the 8-bit register are dropped
                    write_reg(CFG_HIT_CYCLES, CFG_DATA_W'($urandom));
                    write_reg(CFG_MISS_CYCLES, CFG_DATA_W'($urandom));
                    write_reg(CFG_WRITEBACK_CYCLES, CFG_DATA_W'($urandom));
                    write_reg(CFG_SPARE_INDEX, CFG_DATA_W'($urandom));
                end
                3:
                begin
                    write_reg(CFG_HIT_CYCLES, CFG_DATA_W'($urandom_range(0, 255)));
                    write_reg(CFG_MISS_CYCLES, CFG_DATA_W'($urandom_range(0, 1000)));
                    write_reg(CFG_WRITEBACK_CYCLES, CFG_DATA_W'($urandom));
                end
                default:
                begin
                    write_reg(CFG_HIT_CYCLES, CFG_DATA_W'(HIT_CYCLES_RST));
                    write_reg(CFG_MISS_CYCLES, MISS_CYCLES_RST);
                    write_reg(CFG_WRITEBACK_CYCLES, WRITEBACK_CYCLES_RST);
                end
            endcase
            repeat (PHASE_ITEMS)
            begin
                draw_access(a, w, n);
                send_access(a, w, n);
            end
        end

        // all transactions in, wait for the last results
        settle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/dmwbc_pkg.sv
rtl/core/dmwbc_ram.sv
rtl/core/dmwbc_front.sv
rtl/core/dmwbc_back.sv
rtl/core/direct_mapped_writeback_cache_model_top.sv
rtl/core/dmwbc_checker.sv
test/cache_access_checker.sv
test/tb.sv
